/* hw/rtl/apf_pkg.sv */
// ----------------------------------------------------------------------------
// Articulation point finder package
// Field widths, defaults and the command and status bundles that join the
// controller and the datapath.
// ----------------------------------------------------------------------------
package apf_pkg;

  // Fixed field widths of the stream payloads.
  localparam int VERT_W      = 6;
  localparam int IN_DATA_W   = 16;
  localparam int OUT_DATA_W  = 8;

  // Defaults for the top-level parameter and the root register.
  localparam int                MAX_VERTICES_DEF = 64;
  localparam logic [VERT_W-1:0] ROOT_RESET       = 6'd5;

  // Input item kinds carried in the slave tuser bit.
  localparam logic MODE_EDGE = 1'b0;
  localparam logic MODE_RUN  = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_step;    // clear a row of adj, disc, par, cut; advance sweep
    logic in_ready;    // input channel may take a transfer
    logic edge_first;  // set adjacency bit (a, b) from the input
    logic edge_second; // set adjacency bit (b, a) from the saved edge
    logic start;       // visit the root, fetch its row
    logic scan;        // test the next neighbor column
    logic descend;     // visit the candidate as a new child
    logic lower;       // fold candidate discovery time into low-link
    logic finish;      // fetch the parent of the finished vertex
    logic pop;         // fold child into parent, resume parent
    logic root_cut;    // write the root cut flag from the child count
    logic out_rd;      // read the cut flag at the sweep index
    logic out_push;    // move pending result out, hold the new one
    logic sweep_step;  // advance the sweep index during the output scan
    logic out_end;     // emit the final result of the run
  } apf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sweep_last;
    logic in_fire;
    logic in_mode;
    logic edge_ok;
    logic root_ok;
    logic w_end;
    logic cand_hit;
    logic v_is_root;
    logic unvisited;
    logic cut_q;
    logic pend_valid;
    logic out_free;
  } apf_sts_t;

endpackage

/* hw/rtl/apf_ctrl.sv */
// ----------------------------------------------------------------------------
// Articulation point finder controller
// Sequences edge loads, the depth-first walk, the output scan and the
// clearing pass, one command set per cycle.
// ----------------------------------------------------------------------------
module apf_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  apf_pkg::apf_sts_t sts,
  output apf_pkg::apf_cmd_t cmd
);
  import apf_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_EDGE2, S_START, S_ROW_WAIT, S_SCAN, S_CHECK,
    S_POP, S_ROOT_CUT, S_OUT_RD, S_OUT_CHK, S_OUT_END
  } state_t;

  state_t state, state_next;
  logic   out_stall;

  // A new flag waits while an older pending result cannot leave.
  assign out_stall = sts.cut_q && sts.pend_valid && !sts.out_free;

  // Command decode and next state.
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.sweep_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (sts.in_fire) begin
          if (sts.in_mode == MODE_EDGE) begin
            if (sts.edge_ok) begin
              cmd.edge_first = 1'b1;
              state_next     = S_EDGE2;
            end
          end else if (sts.root_ok) begin
            state_next = S_START;
          end else begin
            state_next = S_OUT_RD;
          end
        end
      end
      S_EDGE2: begin
        cmd.edge_second = 1'b1;
        state_next      = S_IDLE;
      end
      S_START: begin
        cmd.start  = 1'b1;
        state_next = S_ROW_WAIT;
      end
      S_ROW_WAIT: begin
        state_next = S_SCAN;
      end
      S_SCAN: begin
        if (sts.w_end) begin
          if (sts.v_is_root) begin
            state_next = S_ROOT_CUT;
          end else begin
            cmd.finish = 1'b1;
            state_next = S_POP;
          end
        end else begin
          cmd.scan = 1'b1;
          if (sts.cand_hit) begin
            state_next = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (sts.unvisited) begin
          cmd.descend = 1'b1;
          state_next  = S_ROW_WAIT;
        end else begin
          cmd.lower  = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_POP: begin
        cmd.pop    = 1'b1;
        state_next = S_SCAN;
      end
      S_ROOT_CUT: begin
        cmd.root_cut = 1'b1;
        state_next   = S_OUT_RD;
      end
      S_OUT_RD: begin
        cmd.out_rd = 1'b1;
        state_next = S_OUT_CHK;
      end
      S_OUT_CHK: begin
        if (!out_stall) begin
          cmd.out_push   = sts.cut_q;
          cmd.sweep_step = 1'b1;
          state_next     = sts.sweep_last ? S_OUT_END : S_OUT_RD;
        end
      end
      S_OUT_END: begin
        if (sts.out_free) begin
          cmd.out_end = 1'b1;
          state_next  = S_CLEAR;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  // State register; reset starts with the clearing pass.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* hw/rtl/apf_dp.sv */
// ----------------------------------------------------------------------------
// Articulation point finder datapath
// Holds the graph and walk stores, the current walk frame, the pending
// result and the output register.
// ----------------------------------------------------------------------------
module apf_dp #(
  parameter int MAX_VERTICES = apf_pkg::MAX_VERTICES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  apf_pkg::apf_cmd_t              cmd,
  output apf_pkg::apf_sts_t              sts,
  input  logic [apf_pkg::VERT_W-1:0]     root_vertex,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [apf_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                           s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [apf_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic                           m_axis_tlast,
  output logic                           m_axis_tuser
);
  import apf_pkg::*;

  localparam int VW = $clog2(MAX_VERTICES);
  localparam logic [VERT_W:0] NV = (VERT_W+1)'(MAX_VERTICES);
  localparam logic [VW:0]     NW = (VW+1)'(MAX_VERTICES);
  localparam logic [VW-1:0]   LAST_IDX = VW'(MAX_VERTICES - 1);
  localparam logic [VW:0]     NONE = {1'b1, {VW{1'b0}}};

  // Stores: one write and one registered read per cycle each.
  logic [MAX_VERTICES-1:0] adj_mem  [MAX_VERTICES];
  logic [VW:0]             disc_mem [MAX_VERTICES];
  logic [VW:0]             par_mem  [MAX_VERTICES];
  logic [VW-1:0]           low_mem  [MAX_VERTICES];
  logic [VW:0]             next_mem [MAX_VERTICES];
  logic                    cut_mem  [MAX_VERTICES];

  logic [MAX_VERTICES-1:0] adj_q;
  logic [VW:0]             disc_q, par_q, next_q;
  logic [VW-1:0]           low_q;
  logic                    cut_q;

  // Control registers and walk frame.
  logic [VW-1:0] sweep;
  logic [VW:0]   time_ctr, children;
  logic [VW-1:0] v, cand, pend_v, ea, eb;
  logic [VW:0]   w, parent_cur;
  logic [VW-1:0] low_cur;
  logic          pend_valid;
  logic          out_valid, out_last, out_none;
  logic [VW-1:0] out_v;

  logic [VERT_W-1:0] in_a, in_b;
  logic [VW-1:0]     ia, ib, root_i, wi, p_i;
  logic [VW-1:0]     disc_ra, adj_ra;
  logic              disc_re, adj_re;
  logic              out_free, out_load;

  assign in_a   = s_axis_tdata[VERT_W-1:0];
  assign in_b   = s_axis_tdata[2*VERT_W-1:VERT_W];
  assign ia     = in_a[VW-1:0];
  assign ib     = in_b[VW-1:0];
  assign root_i = root_vertex[VW-1:0];
  assign wi     = w[VW-1:0];
  assign p_i    = parent_cur[VW-1:0];

  // Status for the controller.
  assign out_free        = !out_valid || m_axis_tready;
  assign sts.sweep_last  = (sweep == LAST_IDX);
  assign sts.in_fire     = s_axis_tvalid && cmd.in_ready;
  assign sts.in_mode     = s_axis_tuser;
  assign sts.edge_ok     = (in_a != in_b) && ({1'b0, in_a} < NV) && ({1'b0, in_b} < NV);
  assign sts.root_ok     = ({1'b0, root_vertex} < NV);
  assign sts.w_end       = (w == NW);
  assign sts.cand_hit    = adj_q[wi] && (wi != v) && (parent_cur != {1'b0, wi});
  assign sts.v_is_root   = (v == root_i);
  assign sts.unvisited   = disc_q[VW];
  assign sts.cut_q       = cut_q;
  assign sts.pend_valid  = pend_valid;
  assign sts.out_free    = out_free;
  assign s_axis_tready   = cmd.in_ready;

  // Read address selection.
  assign disc_re = cmd.scan || cmd.finish;
  assign disc_ra = cmd.scan ? wi : p_i;
  assign adj_re  = cmd.start || cmd.descend || cmd.finish;
  always_comb begin
    if (cmd.start) begin
      adj_ra = root_i;
    end else if (cmd.descend) begin
      adj_ra = cand;
    end else begin
      adj_ra = p_i;
    end
  end

  // Adjacency matrix: row clears, single-bit sets, row reads.
  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      adj_mem[sweep] <= '0;
    end else if (cmd.edge_first) begin
      adj_mem[ia][ib] <= 1'b1;
    end else if (cmd.edge_second) begin
      adj_mem[eb][ea] <= 1'b1;
    end
    if (adj_re) begin
      adj_q <= adj_mem[adj_ra];
    end
  end

  // Discovery times; the top bit marks an unvisited vertex.
  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      disc_mem[sweep] <= NONE;
    end else if (cmd.start) begin
      disc_mem[root_i] <= {1'b0, time_ctr[VW-1:0]};
    end else if (cmd.descend) begin
      disc_mem[cand] <= {1'b0, time_ctr[VW-1:0]};
    end
    if (disc_re) begin
      disc_q <= disc_mem[disc_ra];
    end
  end

  // Parent links, saved low-links and resume columns of open vertices.
  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      par_mem[sweep] <= NONE;
    end else if (cmd.descend) begin
      par_mem[cand] <= {1'b0, v};
    end
    if (cmd.descend) begin
      low_mem[v]  <= low_cur;
      next_mem[v] <= w;
    end
    if (cmd.finish) begin
      par_q  <= par_mem[p_i];
      low_q  <= low_mem[p_i];
      next_q <= next_mem[p_i];
    end
  end

  // Cut flags.
  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      cut_mem[sweep] <= 1'b0;
    end else if (cmd.pop && (low_cur >= disc_q[VW-1:0])) begin
      cut_mem[p_i] <= 1'b1;
    end else if (cmd.root_cut) begin
      cut_mem[root_i] <= (children > (VW+1)'(1));
    end
    if (cmd.out_rd) begin
      cut_q <= cut_mem[sweep];
    end
  end

  // Walk frame: current vertex, scan column, parent and low-link.
  always_ff @(posedge clk) begin
    if (cmd.edge_first) begin
      ea <= ia;
      eb <= ib;
    end
    if (cmd.scan) begin
      cand <= wi;
    end
    if (cmd.start) begin
      v          <= root_i;
      w          <= '0;
      parent_cur <= NONE;
      low_cur    <= time_ctr[VW-1:0];
    end else if (cmd.descend) begin
      v          <= cand;
      w          <= '0;
      parent_cur <= {1'b0, v};
      low_cur    <= time_ctr[VW-1:0];
    end else if (cmd.pop) begin
      v          <= p_i;
      w          <= next_q;
      parent_cur <= par_q;
      low_cur    <= (low_q < low_cur) ? low_q : low_cur;
    end else begin
      if (cmd.scan) begin
        w <= w + 1'b1;
      end
      if (cmd.lower && (disc_q[VW-1:0] < low_cur)) begin
        low_cur <= disc_q[VW-1:0];
      end
    end
  end

  // Sweep index, visit clock and root child count.
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep    <= '0;
      time_ctr <= '0;
      children <= '0;
    end else begin
      if (cmd.clr_step || cmd.sweep_step) begin
        sweep <= (sweep == LAST_IDX) ? '0 : sweep + 1'b1;
      end
      if (cmd.clr_step) begin
        time_ctr <= '0;
        children <= '0;
      end else begin
        if (cmd.start || cmd.descend) begin
          time_ctr <= time_ctr + 1'b1;
        end
        if (cmd.descend && sts.v_is_root) begin
          children <= children + 1'b1;
        end
      end
    end
  end

  // Pending result: one flagged vertex is held back so the last can be marked.
  assign out_load = (cmd.out_push && pend_valid) || cmd.out_end;
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.out_push) begin
        pend_valid <= 1'b1;
      end else if (cmd.out_end || cmd.clr_step) begin
        pend_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (cmd.out_push) begin
      pend_v <= sweep;
    end
    if (out_load) begin
      out_v    <= (cmd.out_end && !pend_valid) ? '0 : pend_v;
      out_last <= cmd.out_end;
      out_none <= cmd.out_end && !pend_valid;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = OUT_DATA_W'(out_v);
  assign m_axis_tlast  = out_last;
  assign m_axis_tuser  = out_none;

  // Visits never outnumber the vertices.
  a_time_bound: assert property (@(posedge clk) disable iff (rst)
    time_ctr <= NW)
    else $error("visit counter exceeded the vertex count");

  // A vertex that finishes below the root always has a parent.
  a_finish_parent: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> !parent_cur[VW])
    else $error("finished vertex without a parent");

  // The final result of a run is always put on the output.
  a_end_emits: assert property (@(posedge clk) disable iff (rst)
    cmd.out_end |=> (out_valid && out_last && !pend_valid))
    else $error("run ended without a last result");

endmodule

/* hw/rtl/articulation_point_finder.sv */
// ----------------------------------------------------------------------------
// Articulation point finder
// Loads an undirected graph edge by edge and reports its cut vertices.
// ----------------------------------------------------------------------------
// Input items arrive on the s_axis channel. tuser 0 loads an edge (a, b)
// into the adjacency matrix; self loops and out-of-range endpoints are
// dropped. tuser 1 runs a depth-first walk from the root register and
// emits the cut vertices in ascending order on m_axis, tlast on the final
// one; a graph without cut vertices gives one transfer with tuser set.
// An edge item sets bit (a, b), then bit (b, a). A run scans the matrix
// row of each visited vertex, tests each neighbor found and returns to the
// parent, then scans every vertex for the output, then runs a clearing
// pass that empties the adjacency, discovery, parent and cut stores for
// the next graph. The same pass runs after reset; no input transfer is
// taken during it. The root register is written through cfg_we/cfg_wdata
// and resets to vertex 5; write it only while the block is idle, which the
// block does not enforce. A stalled receiver holds the output register;
// the output scan waits until the held result leaves; no result is lost.
// ----------------------------------------------------------------------------
module articulation_point_finder #(
  parameter int MAX_VERTICES = apf_pkg::MAX_VERTICES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [apf_pkg::VERT_W-1:0]     cfg_wdata,     // root_vertex
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [apf_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // end_a, end_b
  input  logic                           s_axis_tuser,  // mode
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [apf_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // cut_vertex
  output logic                           m_axis_tlast,  // is_last
  output logic                           m_axis_tuser   // none_found
);
  import apf_pkg::*;

  apf_cmd_t          cmd;
  apf_sts_t          sts;
  logic [VERT_W-1:0] root_vertex;

  // Root vertex register.
  always_ff @(posedge clk) begin
    if (rst) begin
      root_vertex <= ROOT_RESET;
    end else if (cfg_we) begin
      root_vertex <= cfg_wdata;
    end
  end

  apf_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  apf_dp #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .root_vertex   (root_vertex),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

/* bench/articulation_point_finder_test.sv */
// ----------------------------------------------------------------------------
// Articulation point finder testbench
// Loads graphs edge by edge, runs the search and compares every reported cut
// vertex with a behavioral predictor or a typed-in table result. Both stream
// sides idle at random, the receiver stalls for a long stretch once, and the
// root register is rewritten between graphs.
// ----------------------------------------------------------------------------
module articulation_point_finder_test;
  import apf_pkg::*;

  localparam int NV = 64;
  localparam int WATCHDOG_LIMIT = 200000;
  localparam logic [6:0] UNSEEN = 7'h7F;

  typedef struct packed {
    logic       mode;
    logic [5:0] a;
    logic [5:0] b;
  } edge_item_t;

  typedef struct packed {
    logic [5:0] vert;
    logic       last;
    logic       empty;
  } cut_result_t;

  typedef struct packed {
    edge_item_t  it;
    logic        known;
    cut_result_t want;
  } dir_row_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [VERT_W-1:0]     cfg_wdata;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  m_axis_tuser;

  articulation_point_finder DUT (.*);

  // Predictor state.
  logic [63:0] adj [NV];
  logic [5:0]  root_reg;
  cut_result_t cut_queue[$];
  bit          use_fixed = 0;
  cut_result_t fixed_want;

  int  errors = 0;
  int  idle_cycles = 0;
  bit  long_stall = 0;
  bit  stim_done = 0;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // Add one edge to the predicted graph.
  task automatic add_edge(input logic [5:0] a, input logic [5:0] b);
    if (a != b) begin
      adj[a][b] = 1'b1;
      adj[b][a] = 1'b1;
    end
  endtask

  // Walk the predicted graph from the root and queue its cut vertices.
  task automatic predict_cuts();
    logic [6:0] disc [NV];
    logic [5:0] lowv [NV];
    logic [6:0] par [NV];
    logic       cut [NV];
    logic [5:0] stk_v [NV];
    int         stk_n [NV];
    int         depth, top, v, w, cw, p, cnt;
    logic [6:0] tcount, kids;
    bit         went;
    cut_result_t r;
    // Rows with a typed-in result skip the walk.
    if (use_fixed) begin
      cut_queue.push_back(fixed_want);
      for (int i = 0; i < NV; i++) adj[i] = '0;
      return;
    end
    for (int i = 0; i < NV; i++) begin
      disc[i] = UNSEEN; lowv[i] = 0; par[i] = UNSEEN; cut[i] = 0;
    end
    tcount = 0;
    kids = 0;
    disc[root_reg] = tcount & 7'h3F;
    lowv[root_reg] = tcount[5:0];
    tcount++;
    stk_v[0] = root_reg;
    stk_n[0] = 0;
    depth = 1;
    while (depth > 0) begin
      top = depth - 1;
      v = int'(stk_v[top]);
      w = stk_n[top];
      went = 0;
      while (w < NV && !went) begin
        cw = w;
        w++;
        if (!adj[v][cw] || cw == v || cw == par[v]) continue;
        if (disc[cw] == UNSEEN) begin
          par[cw] = 7'(v);
          if (v == root_reg) kids++;
          disc[cw] = tcount & 7'h3F;
          lowv[cw] = tcount[5:0];
          tcount++;
          stk_n[top] = w;
          if (depth < NV) begin
            stk_v[depth] = 6'(cw);
            stk_n[depth] = 0;
            depth++;
          end
          went = 1;
        end else if (disc[cw] < lowv[v]) begin
          lowv[v] = disc[cw][5:0];
        end
      end
      if (went) continue;
      depth--;
      if (depth > 0) begin
        p = int'(stk_v[depth - 1]);
        if (lowv[v] >= disc[p]) cut[p] = 1;
        if (lowv[v] < lowv[p]) lowv[p] = lowv[v];
      end
    end
    cut[root_reg] = kids > 1;
    cnt = 0;
    for (int i = 0; i < NV; i++) begin
      if (cut[i]) begin
        r.vert = 6'(i); r.last = 0; r.empty = 0;
        cut_queue.push_back(r);
        cnt++;
      end
    end
    if (cnt == 0) begin
      r.vert = 0; r.last = 1; r.empty = 1;
      cut_queue.push_back(r);
    end else begin
      cut_queue[$].last = 1;
    end
    for (int i = 0; i < NV; i++) adj[i] = '0;
  endtask

  // Send one item and update the predictor once it is accepted. tvalid stays
  // high into the next item when that one does not idle.
  task automatic send_item(input edge_item_t it);
    int n;
    n = $urandom_range(0, 15);
    if (n > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.mode;
    s_axis_tdata  <= {4'b0, it.b, it.a};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (it.mode == MODE_EDGE) add_edge(it.a, it.b);
    else predict_cuts();
    @(negedge clk);
  endtask

  // Wait for all results, then give a trailing clearing pass time to finish.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (cut_queue.size() != 0) @(negedge clk);
    repeat (2 * NV + 8) @(negedge clk);
  endtask

  task automatic write_root(input logic [5:0] r);
    cfg_we <= 1'b1;
    cfg_wdata <= r;
    @(negedge clk);
    cfg_we <= 1'b0;
    root_reg = r;
  endtask

  // Random graph built as a chain with extra chords over a small vertex range.
  task automatic random_graph(input int span);
    edge_item_t it;
    int n;
    logic [5:0] lo;
    lo = 6'($urandom_range(0, 63 - span));
    n = $urandom_range(1, 12);
    for (int k = 0; k < n; k++) begin
      it.mode = MODE_EDGE;
      if ($urandom_range(0, 3) != 0 && k < span) begin
        it.a = 6'(int'(lo) + k); it.b = 6'(int'(lo) + k + 1);
      end else begin
        it.a = 6'(int'(lo) + $urandom_range(0, span));
        it.b = 6'(int'(lo) + $urandom_range(0, span));
      end
      if ($urandom_range(0, 9) == 0) it.a = 6'($urandom_range(0, 63));
      send_item(it);
    end
    it.mode = MODE_RUN;
    it.a = 6'($urandom_range(0, 63));
    it.b = 6'($urandom_range(0, 63));
    send_item(it);
  endtask

  // Directed stimulus table: {{mode, end_a, end_b}, typed, {vertex, last, empty}}.
  dir_row_t directed [] = '{
    '{'{MODE_RUN, 6'd0, 6'd0}, 1'b1, '{6'd0, 1'b1, 1'b1}},    // empty graph: none
    '{'{MODE_EDGE, 6'd5, 6'd5}, 1'b0, '{6'd0, 1'b0, 1'b0}},   // self loop ignored
    '{'{MODE_EDGE, 6'd4, 6'd5}, 1'b0, '{6'd0, 1'b0, 1'b0}},
    '{'{MODE_EDGE, 6'd5, 6'd6}, 1'b0, '{6'd0, 1'b0, 1'b0}},
    '{'{MODE_EDGE, 6'd5, 6'd6}, 1'b0, '{6'd0, 1'b0, 1'b0}},   // repeated edge
    '{'{MODE_RUN, 6'd63, 6'd63}, 1'b1, '{6'd5, 1'b1, 1'b0}},  // root 5, two children
    '{'{MODE_EDGE, 6'd0, 6'd63}, 1'b0, '{6'd0, 1'b0, 1'b0}},
    '{'{MODE_EDGE, 6'd63, 6'd5}, 1'b0, '{6'd0, 1'b0, 1'b0}},
    '{'{MODE_EDGE, 6'd5, 6'd62}, 1'b0, '{6'd0, 1'b0, 1'b0}},
    '{'{MODE_EDGE, 6'd62, 6'd0}, 1'b0, '{6'd0, 1'b0, 1'b0}},
    '{'{MODE_EDGE, 6'd62, 6'd1}, 1'b0, '{6'd0, 1'b0, 1'b0}},
    '{'{MODE_RUN, 6'd0, 6'd0}, 1'b0, '{6'd0, 1'b0, 1'b0}}
  };

  // Stimulus.
  initial begin
    edge_item_t it;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    root_reg = ROOT_RESET;
    for (int i = 0; i < NV; i++) adj[i] = '0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    foreach (directed[i]) begin
      use_fixed  = directed[i].known;
      fixed_want = directed[i].want;
      send_item(directed[i].it);
    end
    use_fixed = 0;
    drain();
    // Extreme roots on a long path.
    for (int j = 0; j < 2; j++) begin
      write_root(j == 0 ? 6'd0 : 6'd63);
      for (int k = 0; k < 63; k++) begin
        it.mode = MODE_EDGE; it.a = 6'(k); it.b = 6'(k + 1);
        send_item(it);
      end
      it.mode = MODE_RUN; it.a = 0; it.b = 0;
      send_item(it);
      drain();
    end
    // Random graphs with a new root now and then.
    for (int g = 0; g < 50; g++) begin
      if (g % 8 == 0) begin
        drain();
        write_root(6'($urandom_range(0, 63)));
      end
      if (g == 20) long_stall = 1;
      random_graph($urandom_range(2, 12));
    end
    drain();
    stim_done = 1;
  end

  // Receiver: a random wait before each transfer, plus one long hold-off.
  initial begin
    int n;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_stall) begin
        m_axis_tready <= 1'b0;
        repeat (400) @(negedge clk);
        long_stall = 0;
      end
      n = $urandom_range(0, 15);
      if (n > 0) begin
        m_axis_tready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!(m_axis_tvalid && m_axis_tready)) @(posedge clk);
    end
  end

  // Result checker.
  always @(posedge clk) begin
    cut_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (cut_queue.size() == 0) begin
        $display("%0t unexpected result: vertex %0d last %0b empty %0b",
                 $time, m_axis_tdata[5:0], m_axis_tlast, m_axis_tuser);
        errors++;
      end else begin
        want = cut_queue.pop_front();
        if (m_axis_tdata != {2'b0, want.vert} || m_axis_tlast != want.last ||
            m_axis_tuser != want.empty) begin
          $display("%0t mismatch: expected vertex %0d last %0b empty %0b, got %0d %0b %0b",
                   $time, want.vert, want.last, want.empty,
                   m_axis_tdata, m_axis_tlast, m_axis_tuser);
          errors++;
        end
      end
    end
  end

  // Watchdog and end of run.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else if (stim_done) begin
      if (errors == 0 && cut_queue.size() == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
    end
  end

endmodule
